>>> src/tdt_pkg.sv
// shared types and constants of the delay timer table
package tdt_pkg;

    localparam int NUM_SLOTS = 16;
    localparam int RESULT_CAP = 16;
    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int IDX_CNT_W = $clog2(NUM_SLOTS + 1);
    localparam int CAP_W = $clog2(RESULT_CAP + 1);
    localparam int DIV_STEPS = 32;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam logic [15:0] TICK_LENGTH_RESET = 16'd1000;

    localparam logic [1:0] REQ_ARM_SPLIT = 2'd0;
    localparam logic [1:0] REQ_ARM_TOTAL = 2'd1;
    localparam logic [1:0] REQ_CANCEL = 2'd2;
    localparam logic [1:0] REQ_ELAPSE = 2'd3;

    localparam logic [1:0] EV_ARMED = 2'd0;
    localparam logic [1:0] EV_CANCELLED = 2'd1;
    localparam logic [1:0] EV_EXPIRED = 2'd2;

    typedef logic [SLOT_W-1:0] slot_idx_t;

    typedef struct packed {
        logic [31:0] ticks;
        logic [15:0] sub;
    } slot_ent_t;

    typedef struct packed {
        logic      we;
        slot_idx_t addr;
        slot_ent_t data;
    } ram_wr_t;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_DIV   = 5'b00010,
        ST_EMIT  = 5'b00100,
        ST_WALK  = 5'b01000,
        ST_FLUSH = 5'b10000
    } state_t;

endpackage

>>> src/tdt_slot_ram.sv
// slot countdown memory, one write port and one registered read port
module tdt_slot_ram (
    input  logic                clk,
    input  tdt_pkg::ram_wr_t    wr,
    input  logic                rd_en,
    input  tdt_pkg::slot_idx_t  rd_addr,
    output tdt_pkg::slot_ent_t  rd_data
);

    tdt_pkg::slot_ent_t mem_reg [tdt_pkg::NUM_SLOTS];
    tdt_pkg::slot_ent_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem_reg[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> src/tdt_div.sv
// restoring divider, one quotient bit per cycle
module tdt_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [15:0] divisor,
    output logic        done,
    output logic [31:0] quotient,
    output logic [15:0] remainder
);

    logic                          busy_reg;
    logic                          done_reg;
    logic [tdt_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic [31:0]                   quo_reg;
    logic [15:0]                   rem_reg;
    logic [15:0]                   divisor_reg;
    logic [16:0]                   trial;
    logic                          ge;

    assign trial = {rem_reg, quo_reg[31]};
    assign ge = trial >= {1'b0, divisor_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == tdt_pkg::DIV_CNT_W'(tdt_pkg::DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg     <= dividend;
            rem_reg     <= '0;
            divisor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[30:0], ge};
            rem_reg <= ge ? 16'(trial - {1'b0, divisor_reg}) : trial[15:0];
        end
    end

    assign done = done_reg;
    assign quotient = quo_reg;
    assign remainder = rem_reg;

endmodule

>>> src/task_delay_timer_table_core.sv
// delay timer table top level: request handling, slot walk and result output
//
//  channel   | valid/ready                 | payload
//  ----------+-----------------------------+------------------------------------------
//  request   | s_axis_tvalid/s_axis_tready | tuser req_type, tdata slot..elapsed
//  event     | m_axis_tvalid/m_axis_tready | tuser event_kind, tdata event_slot, tlast
//  config    | cfg_we (no ready)           | cfg_wdata tick_length
//
// cancel and arm split go through ST_EMIT, arm from total through ST_DIV first (32-step divider)
// elapse reads one slot per cycle from the slot memory while the walk is not stalled
// a full event register stalls the walk at the next expiry once an earlier expiry is held
// reset clears all slots at once through per-slot pending flags
// requests are taken only while no earlier request is in progress
module task_delay_timer_table_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,  // slot, delay_ticks, delay_sub, elapsed, zero pad
    input  logic [1:0]  s_axis_tuser,  // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // event_slot, zero pad
    output logic [1:0]  m_axis_tuser,  // event_kind
    output logic        m_axis_tlast
);

    tdt_pkg::state_t state_reg, state_next;

    logic [15:0] tick_length_reg;
    logic [15:0] tl_eff;

    logic [tdt_pkg::NUM_SLOTS-1:0] pend_reg, pend_next;

    tdt_pkg::slot_idx_t slot_reg, slot_next;
    logic [1:0]         kind_reg, kind_next;
    logic [15:0]        dec_reg, dec_next;

    logic [tdt_pkg::IDX_CNT_W-1:0] rd_idx_reg, rd_idx_next;
    logic                          s1_vld_reg, s1_vld_next;
    tdt_pkg::slot_idx_t            s1_idx_reg, s1_idx_next;
    logic [tdt_pkg::CAP_W-1:0]     cnt_reg, cnt_next;
    logic                          hold_vld_reg, hold_vld_next;
    tdt_pkg::slot_idx_t            hold_idx_reg, hold_idx_next;

    logic       out_valid_reg, out_valid_next;
    logic [3:0] out_slot_reg, out_slot_next;
    logic [1:0] out_kind_reg, out_kind_next;
    logic       out_last_reg, out_last_next;

    logic [3:0]  in_slot;
    logic [31:0] in_ticks;
    logic [15:0] in_sub;
    logic [15:0] in_elapsed;
    logic        in_take;
    logic        slot_ok;
    tdt_pkg::slot_idx_t in_idx;

    tdt_pkg::ram_wr_t   ram_wr;
    logic               rd_en;
    tdt_pkg::slot_idx_t rd_addr;
    tdt_pkg::slot_ent_t rd_data;
    tdt_pkg::slot_ent_t upd;

    logic        div_start;
    logic        div_done;
    logic [31:0] div_quo;
    logic [15:0] div_rem;

    logic out_free;
    logic s1_work;
    logic expire;
    logic stall;
    logic walk_done;
    logic push;
    logic [3:0] push_slot;
    logic [1:0] push_kind;
    logic push_last;

    tdt_slot_ram u_ram (
        .clk     (clk),
        .wr      (ram_wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    tdt_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (in_ticks),
        .divisor   (tl_eff),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign in_slot = s_axis_tdata[3:0];
    assign in_ticks = s_axis_tdata[35:4];
    assign in_sub = s_axis_tdata[51:36];
    assign in_elapsed = s_axis_tdata[67:52];
    assign in_idx = tdt_pkg::slot_idx_t'(in_slot);
    assign slot_ok = 32'(in_slot) < tdt_pkg::NUM_SLOTS;

    assign tl_eff = (tick_length_reg == 16'd0) ? 16'd1 : tick_length_reg;
    assign s_axis_tready = state_reg == tdt_pkg::ST_IDLE;
    assign in_take = s_axis_tvalid && s_axis_tready;
    assign out_free = !out_valid_reg || m_axis_tready;

    // countdown step of the slot on the read port
    always_comb
    begin
        upd = rd_data;
        if (dec_reg >= rd_data.sub)
        begin
            if (rd_data.ticks == 32'd0)
            begin
                upd.sub = 16'd0;
            end
            else
            begin
                upd.ticks = rd_data.ticks - 32'd1;
                upd.sub = tl_eff - (dec_reg - rd_data.sub);
            end
        end
        else
        begin
            upd.sub = rd_data.sub - dec_reg;
        end
    end

    assign s1_work = (state_reg == tdt_pkg::ST_WALK) && s1_vld_reg && pend_reg[s1_idx_reg]
                     && (cnt_reg != tdt_pkg::CAP_W'(tdt_pkg::RESULT_CAP));
    assign expire = (upd.ticks == 32'd0) && (upd.sub == 16'd0);
    assign stall = s1_work && expire && hold_vld_reg && !out_free;
    assign walk_done = (!s1_vld_reg && rd_idx_reg == tdt_pkg::IDX_CNT_W'(tdt_pkg::NUM_SLOTS))
                       || cnt_reg == tdt_pkg::CAP_W'(tdt_pkg::RESULT_CAP);
    assign rd_addr = tdt_pkg::slot_idx_t'(rd_idx_reg);
    assign rd_en = (state_reg == tdt_pkg::ST_WALK) && !stall && !walk_done
                   && rd_idx_reg != tdt_pkg::IDX_CNT_W'(tdt_pkg::NUM_SLOTS);

    always_comb
    begin
        state_next    = state_reg;
        pend_next     = pend_reg;
        slot_next     = slot_reg;
        kind_next     = kind_reg;
        dec_next      = dec_reg;
        rd_idx_next   = rd_idx_reg;
        s1_vld_next   = s1_vld_reg;
        s1_idx_next   = s1_idx_reg;
        cnt_next      = cnt_reg;
        hold_vld_next = hold_vld_reg;
        hold_idx_next = hold_idx_reg;
        ram_wr        = '0;
        div_start     = 1'b0;
        push          = 1'b0;
        push_slot     = '0;
        push_kind     = tdt_pkg::EV_EXPIRED;
        push_last     = 1'b0;

        case (state_reg)
            tdt_pkg::ST_IDLE:
            begin
                slot_next = in_idx;
                if (in_take)
                begin
                    case (s_axis_tuser)
                        tdt_pkg::REQ_ARM_SPLIT:
                        begin
                            if (slot_ok)
                            begin
                                ram_wr.we = 1'b1;
                                ram_wr.addr = in_idx;
                                ram_wr.data = '{ticks: in_ticks, sub: in_sub};
                                pend_next[in_idx] = 1'b1;
                                kind_next = tdt_pkg::EV_ARMED;
                                state_next = tdt_pkg::ST_EMIT;
                            end
                        end
                        tdt_pkg::REQ_ARM_TOTAL:
                        begin
                            if (slot_ok)
                            begin
                                div_start = 1'b1;
                                state_next = tdt_pkg::ST_DIV;
                            end
                        end
                        tdt_pkg::REQ_CANCEL:
                        begin
                            if (slot_ok)
                            begin
                                pend_next[in_idx] = 1'b0;
                                kind_next = tdt_pkg::EV_CANCELLED;
                                state_next = tdt_pkg::ST_EMIT;
                            end
                        end
                        default:
                        begin
                            dec_next = (in_elapsed > tl_eff) ? tl_eff : in_elapsed;
                            rd_idx_next = '0;
                            s1_vld_next = 1'b0;
                            cnt_next = '0;
                            hold_vld_next = 1'b0;
                            state_next = tdt_pkg::ST_WALK;
                        end
                    endcase
                end
            end
            tdt_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    ram_wr.we = 1'b1;
                    ram_wr.addr = slot_reg;
                    ram_wr.data = '{ticks: div_quo, sub: div_rem};
                    pend_next[slot_reg] = 1'b1;
                    kind_next = tdt_pkg::EV_ARMED;
                    state_next = tdt_pkg::ST_EMIT;
                end
            end
            tdt_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    push = 1'b1;
                    push_slot = 4'(slot_reg);
                    push_kind = kind_reg;
                    push_last = 1'b1;
                    state_next = tdt_pkg::ST_IDLE;
                end
            end
            tdt_pkg::ST_WALK:
            begin
                if (!stall)
                begin
                    if (s1_work)
                    begin
                        ram_wr.we = 1'b1;
                        ram_wr.addr = s1_idx_reg;
                        ram_wr.data = upd;
                        if (expire)
                        begin
                            pend_next[s1_idx_reg] = 1'b0;
                            cnt_next = cnt_reg + 1'b1;
                            hold_vld_next = 1'b1;
                            hold_idx_next = s1_idx_reg;
                            if (hold_vld_reg)
                            begin
                                push = 1'b1;
                                push_slot = 4'(hold_idx_reg);
                            end
                        end
                    end
                    if (walk_done)
                    begin
                        s1_vld_next = 1'b0;
                        state_next = tdt_pkg::ST_FLUSH;
                    end
                    else
                    begin
                        s1_vld_next = rd_en;
                        s1_idx_next = rd_addr;
                        if (rd_en)
                        begin
                            rd_idx_next = rd_idx_reg + 1'b1;
                        end
                    end
                end
            end
            tdt_pkg::ST_FLUSH:
            begin
                if (!hold_vld_reg)
                begin
                    state_next = tdt_pkg::ST_IDLE;
                end
                else if (out_free)
                begin
                    push = 1'b1;
                    push_slot = 4'(hold_idx_reg);
                    push_last = 1'b1;
                    hold_vld_next = 1'b0;
                    state_next = tdt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tdt_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_slot_next  = out_slot_reg;
        out_kind_next  = out_kind_reg;
        out_last_next  = out_last_reg;
        if (push)
        begin
            out_valid_next = 1'b1;
            out_slot_next  = push_slot;
            out_kind_next  = push_kind;
            out_last_next  = push_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= tdt_pkg::ST_IDLE;
            tick_length_reg <= tdt_pkg::TICK_LENGTH_RESET;
            pend_reg        <= '0;
            s1_vld_reg      <= 1'b0;
            hold_vld_reg    <= 1'b0;
            cnt_reg         <= '0;
            rd_idx_reg      <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            s1_vld_reg    <= s1_vld_next;
            hold_vld_reg  <= hold_vld_next;
            cnt_reg       <= cnt_next;
            rd_idx_reg    <= rd_idx_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                tick_length_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg     <= slot_next;
        kind_reg     <= kind_next;
        dec_reg      <= dec_next;
        s1_idx_reg   <= s1_idx_next;
        hold_idx_reg <= hold_idx_next;
        out_slot_reg <= out_slot_next;
        out_kind_reg <= out_kind_next;
        out_last_reg <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = {4'd0, out_slot_reg};
    assign m_axis_tuser = out_kind_reg;
    assign m_axis_tlast = out_last_reg;

endmodule

>>> tb/task_delay_timer_table_core_tb.sv
// self-checking testbench for the delay timer table core
`timescale 1ns / 100ps

module task_delay_timer_table_core_tb;

    localparam int TIMEOUT_CYCLES = 600000;
    localparam int DRAIN_CYCLES = 60;

    typedef struct {
        logic [1:0]  kind;
        logic [3:0]  slot;
        logic [31:0] ticks;
        logic [15:0] sub;
        logic [15:0] elapsed;
    } timer_req_t;

    typedef struct {
        logic [1:0] kind;
        logic [3:0] slot;
        logic       is_last;
    } timer_event_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_wdata = 16'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = 72'd0;  // slot, delay_ticks, delay_sub, elapsed, zero pad
    logic [1:0]  s_axis_tuser = 2'd0;   // req_type
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;          // event_slot, zero pad
    logic [1:0]  m_axis_tuser;          // event_kind
    logic        m_axis_tlast;

    timer_req_t   req_backlog[$];
    timer_event_t due_events[$];

    // predictor copy of the block state
    logic [15:0] tick_len = tdt_pkg::TICK_LENGTH_RESET;
    logic        slot_armed[tdt_pkg::NUM_SLOTS];
    logic        slot_wait[tdt_pkg::NUM_SLOTS];
    logic [31:0] ticks_rem[tdt_pkg::NUM_SLOTS];
    logic [31:0] sub_rem[tdt_pkg::NUM_SLOTS];

    int  err_count = 0;
    int  reqs_queued = 0;
    int  reqs_accepted = 0;
    int  arm_count = 0;
    int  cancel_count = 0;
    int  elapse_count = 0;
    int  expiry_count = 0;
    int  cfg_count = 0;
    int  cycle_count = 0;
    int  tx_idle_pct = 0;
    int  rx_stall_pct = 0;
    logic req_taken = 1'b0;

    task_delay_timer_table_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        err_count++;
    endtask

    task automatic predict_timer_events(input timer_req_t r);
        logic [31:0] tl;
        logic [31:0] dec;
        int n;
        timer_event_t ev;
        tl = (tick_len == 16'd0) ? 32'd1 : {16'd0, tick_len};
        ev.is_last = 1'b0;
        case (r.kind)
            tdt_pkg::REQ_CANCEL:
            begin
                slot_armed[r.slot] = 1'b0;
                slot_wait[r.slot] = 1'b0;
                ev.kind = tdt_pkg::EV_CANCELLED;
                ev.slot = r.slot;
                ev.is_last = 1'b1;
                due_events.push_back(ev);
                cancel_count++;
            end
            tdt_pkg::REQ_ARM_SPLIT, tdt_pkg::REQ_ARM_TOTAL:
            begin
                if (r.kind == tdt_pkg::REQ_ARM_SPLIT)
                begin
                    ticks_rem[r.slot] = r.ticks;
                    sub_rem[r.slot] = {16'd0, r.sub};
                end
                else
                begin
                    ticks_rem[r.slot] = r.ticks / tl;
                    sub_rem[r.slot] = r.ticks % tl;
                end
                slot_armed[r.slot] = 1'b1;
                slot_wait[r.slot] = 1'b1;
                ev.kind = tdt_pkg::EV_ARMED;
                ev.slot = r.slot;
                ev.is_last = 1'b1;
                due_events.push_back(ev);
                arm_count++;
            end
            default:
            begin
                dec = ({16'd0, r.elapsed} > tl) ? tl : {16'd0, r.elapsed};
                n = 0;
                for (int i = 0; i < tdt_pkg::NUM_SLOTS && n < tdt_pkg::RESULT_CAP; i++)
                begin
                    if (slot_armed[i] && slot_wait[i])
                    begin
                        if (dec >= sub_rem[i])
                        begin
                            if (ticks_rem[i] == 32'd0)
                                sub_rem[i] = 32'd0;
                            else
                            begin
                                ticks_rem[i] = ticks_rem[i] - 32'd1;
                                sub_rem[i] = tl - (dec - sub_rem[i]);
                            end
                        end
                        else
                            sub_rem[i] = sub_rem[i] - dec;
                        if (ticks_rem[i] == 32'd0 && sub_rem[i] == 32'd0)
                        begin
                            slot_wait[i] = 1'b0;
                            ev.kind = tdt_pkg::EV_EXPIRED;
                            ev.slot = i[3:0];
                            due_events.push_back(ev);
                            n++;
                        end
                    end
                end
                if (n > 0)
                    due_events[due_events.size() - 1].is_last = 1'b1;
                elapse_count++;
            end
        endcase
    endtask

    // request driver
    always @(negedge clk)
    begin
        timer_req_t r;
        if (rst_n && (!s_axis_tvalid || req_taken))
        begin
            if (req_backlog.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct)
            begin
                r = req_backlog.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser <= r.kind;
                s_axis_tdata <= {4'd0, r.elapsed, r.sub, r.ticks, r.slot};
            end
            else
                s_axis_tvalid <= 1'b0;
        end
        m_axis_tready <= rst_n && ($urandom_range(0, 99) >= rx_stall_pct);
    end

    // monitor: predict on accepted requests, check accepted events
    always @(posedge clk)
    begin
        timer_req_t r;
        timer_event_t exp_ev;
        cycle_count++;
        if (cycle_count >= TIMEOUT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("task_delay_timer_table_core_tb: errors");
            $finish;
        end
        else if (rst_n)
        begin
            req_taken <= s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready)
            begin
                r.kind = s_axis_tuser;
                r.slot = s_axis_tdata[3:0];
                r.ticks = s_axis_tdata[35:4];
                r.sub = s_axis_tdata[51:36];
                r.elapsed = s_axis_tdata[67:52];
                predict_timer_events(r);
                reqs_accepted++;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (due_events.size() == 0)
                    report_mismatch($sformatf("unexpected event kind %0d slot %0d",
                                              m_axis_tuser, m_axis_tdata[3:0]));
                else
                begin
                    exp_ev = due_events.pop_front();
                    if (m_axis_tuser !== exp_ev.kind)
                        report_mismatch($sformatf("event_kind %0d, expected %0d",
                                                  m_axis_tuser, exp_ev.kind));
                    if (m_axis_tdata[3:0] !== exp_ev.slot)
                        report_mismatch($sformatf("event_slot %0d, expected %0d",
                                                  m_axis_tdata[3:0], exp_ev.slot));
                    if (m_axis_tlast !== exp_ev.is_last)
                        report_mismatch($sformatf("tlast %0b, expected %0b on slot %0d",
                                                  m_axis_tlast, exp_ev.is_last, exp_ev.slot));
                    if (exp_ev.kind == tdt_pkg::EV_EXPIRED)
                        expiry_count++;
                end
            end
        end
    end

    task automatic queue_request(input logic [1:0] kind, input logic [3:0] slot,
                                 input logic [31:0] ticks, input logic [15:0] sub,
                                 input logic [15:0] elapsed);
        timer_req_t r;
        r.kind = kind;
        r.slot = slot;
        r.ticks = ticks;
        r.sub = sub;
        r.elapsed = elapsed;
        req_backlog.push_back(r);
        reqs_queued++;
    endtask

    task automatic queue_random_request();
        int tl;
        int pick;
        logic [31:0] ticks;
        logic [15:0] sub;
        logic [15:0] elapsed;
        tl = (tick_len == 16'd0) ? 1 : int'(tick_len);
        pick = $urandom_range(0, 99);
        ticks = $urandom;
        sub = 16'($urandom);
        elapsed = 16'($urandom);
        if (pick < 27)
        begin
            if ($urandom_range(0, 9) < 8)
                ticks = $urandom_range(0, 3);
            if ($urandom_range(0, 9) < 8)
                sub = 16'($urandom_range(0, (2 * tl > 65535) ? 65535 : 2 * tl));
            queue_request(tdt_pkg::REQ_ARM_SPLIT, 4'($urandom_range(0, 15)),
                          ticks, sub, elapsed);
        end
        else if (pick < 42)
        begin
            if ($urandom_range(0, 9) < 8)
                ticks = $urandom_range(0, 4 * tl);
            queue_request(tdt_pkg::REQ_ARM_TOTAL, 4'($urandom_range(0, 15)),
                          ticks, sub, elapsed);
        end
        else if (pick < 50)
            queue_request(tdt_pkg::REQ_CANCEL, 4'($urandom_range(0, 15)),
                          ticks, sub, elapsed);
        else
        begin
            case ($urandom_range(0, 3))
                0: elapsed = tl[15:0];
                1: elapsed = 16'($urandom_range(0, tl));
                2: elapsed = 16'($urandom_range(0, 3));
                default: ;
            endcase
            queue_request(tdt_pkg::REQ_ELAPSE, 4'($urandom_range(0, 15)),
                          ticks, sub, elapsed);
        end
    endtask

    // wait until everything sent has been answered, plus the block's own tail
    task automatic wait_drained();
        while (reqs_accepted != reqs_queued || due_events.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_tick_length(input logic [15:0] value);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        tick_len = value;
        cfg_count++;
    endtask

    initial
    begin
        logic [15:0] phase_ticks[5];
        for (int i = 0; i < tdt_pkg::NUM_SLOTS; i++)
        begin
            slot_armed[i] = 1'b0;
            slot_wait[i] = 1'b0;
            ticks_rem[i] = 32'd0;
            sub_rem[i] = 32'd0;
        end
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed, reset tick length
        queue_request(tdt_pkg::REQ_ARM_SPLIT, 4'd0, 32'd0, 16'd0, 16'd0);
        queue_request(tdt_pkg::REQ_ARM_SPLIT, 4'd15, 32'hFFFF_FFFF, 16'hFFFF, 16'd0);
        queue_request(tdt_pkg::REQ_ARM_TOTAL, 4'd3, 32'd2500, 16'd0, 16'd0);
        queue_request(tdt_pkg::REQ_ARM_TOTAL, 4'd4, 32'hFFFF_FFFF, 16'd0, 16'd0);
        queue_request(tdt_pkg::REQ_ARM_SPLIT, 4'd5, 32'd0, 16'd2000, 16'd0);
        queue_request(tdt_pkg::REQ_ARM_SPLIT, 4'd6, 32'd2, 16'd0, 16'd0);
        queue_request(tdt_pkg::REQ_CANCEL, 4'd7, 32'd0, 16'd0, 16'd0);
        queue_request(tdt_pkg::REQ_ELAPSE, 4'd0, 32'd0, 16'd0, 16'hFFFF);
        queue_request(tdt_pkg::REQ_ELAPSE, 4'd0, 32'd0, 16'd0, 16'd0);
        queue_request(tdt_pkg::REQ_CANCEL, 4'd15, 32'd0, 16'd0, 16'd0);
        queue_request(tdt_pkg::REQ_ARM_SPLIT, 4'd3, 32'd0, 16'd1, 16'd0);
        queue_request(tdt_pkg::REQ_ELAPSE, 4'd0, 32'd0, 16'd0, 16'd1000);
        queue_request(tdt_pkg::REQ_ELAPSE, 4'd0, 32'd0, 16'd0, 16'd999);
        queue_request(tdt_pkg::REQ_ARM_TOTAL, 4'd9, 32'd0, 16'd0, 16'd0);
        queue_request(tdt_pkg::REQ_ELAPSE, 4'd0, 32'd0, 16'd0, 16'd1);
        queue_request(tdt_pkg::REQ_ELAPSE, 4'd0, 32'd0, 16'd0, 16'd1000);
        wait_drained();

        phase_ticks[0] = 16'd0;
        phase_ticks[1] = 16'hFFFF;
        phase_ticks[2] = 16'd1;
        phase_ticks[3] = 16'($urandom_range(2, 65534));
        phase_ticks[4] = tdt_pkg::TICK_LENGTH_RESET;
        for (int p = 0; p < 5; p++)
        begin
            write_tick_length(phase_ticks[p]);
            case (p % 4)
                0: begin tx_idle_pct = 69; rx_stall_pct = 0; end
                1: begin tx_idle_pct = 0; rx_stall_pct = 69; end
                2: begin tx_idle_pct = 11; rx_stall_pct = 11; end
                default: begin tx_idle_pct = 0; rx_stall_pct = 0; end
            endcase
            // every slot expiring on one elapse fills the result cap
            if (p == 1)
            begin
                for (int s = 0; s < tdt_pkg::NUM_SLOTS; s++)
                    queue_request(tdt_pkg::REQ_ARM_SPLIT, s[3:0], 32'd0, 16'd0, 16'd0);
                queue_request(tdt_pkg::REQ_ELAPSE, 4'd0, 32'd0, 16'd0, 16'd0);
            end
            for (int k = 0; k < 24; k++)
                queue_random_request();
            wait_drained();
        end

        $display("covered %0d arm, %0d cancel, %0d elapse transactions, %0d expiries",
                 arm_count, cancel_count, elapse_count, expiry_count);
        $display("over %0d tick_length writes (zero, one, max, random), %0d mismatches",
                 cfg_count, err_count);
        if (err_count == 0)
            $display("task_delay_timer_table_core_tb: clean");
        else
            $display("task_delay_timer_table_core_tb: errors");
        $finish;
    end

endmodule

>>> filelist.f
src/tdt_pkg.sv
src/tdt_slot_ram.sv
src/tdt_div.sv
src/task_delay_timer_table_core.sv
tb/task_delay_timer_table_core_tb.sv
